// ===== src/jhse_pkg.sv =====
package jhse_pkg;

    localparam int NUM_LENGTHS = 16;
    localparam int NUM_AC_SYMS = 162;
    localparam int NUM_DC_SYMS = 12;
    localparam int ROM_DEPTH   = 256;
    localparam int CODE_W      = 16;
    localparam int LEN_W       = 5;
    localparam int EXTRA_W     = 11;
    localparam int CAT_W       = 4;
    localparam int SYM_W       = 8;
    localparam int VALUE_W     = 12;
    localparam int CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DC_TABLE_SEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC_TABLE_SEL = 2'd1;

    // item kinds
    localparam logic FUNC_DC = 1'b0;
    localparam logic FUNC_AC = 1'b1;

    typedef logic [0:NUM_LENGTHS-1][7:0]        t_counts;
    typedef logic [0:NUM_AC_SYMS-1][SYM_W-1:0]  t_syms;
    typedef logic [LEN_W+CODE_W-1:0]            t_rom_entry;
    typedef logic [0:ROM_DEPTH-1][LEN_W+CODE_W-1:0] t_rom;

    // classified item passed from front to back
    typedef struct packed {
        logic               is_ac;
        logic [SYM_W-1:0]   sym;
        logic [EXTRA_W-1:0] extra;
        logic [CAT_W-1:0]   cat;
    } t_item;

    typedef struct packed {
        logic dc_sel;
        logic ac_sel;
    } t_cfg;

    localparam t_counts DC_LUMA_COUNTS =
        {8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
         8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    localparam t_counts DC_CHROMA_COUNTS =
        {8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
         8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    localparam t_counts AC_LUMA_COUNTS =
        {8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
         8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d};
    localparam t_counts AC_CHROMA_COUNTS =
        {8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
         8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77};

    localparam t_syms AC_LUMA_SYMS = {
        8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,
        8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,8'h61,8'h07,
        8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,
        8'h23,8'h42,8'hb1,8'hc1,8'h15,8'h52,8'hd1,8'hf0,
        8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,
        8'h17,8'h18,8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,
        8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
        8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,
        8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,
        8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,
        8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,
        8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
        8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,
        8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
        8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,
        8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,
        8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,
        8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,8'he1,8'he2,
        8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,
        8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,
        8'hf9,8'hfa
    };

    localparam t_syms AC_CHROMA_SYMS = {
        8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,
        8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,8'h61,8'h71,
        8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,
        8'ha1,8'hb1,8'hc1,8'h09,8'h23,8'h33,8'h52,8'hf0,
        8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,
        8'he1,8'h25,8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,
        8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
        8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,
        8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,
        8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,
        8'h69,8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,
        8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,
        8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,
        8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
        8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,
        8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
        8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,
        8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,
        8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,
        8'hea,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,
        8'hf9,8'hfa
    };

    // dc symbols are the categories in order
    function automatic t_syms make_dc_syms();
        t_syms s;
        s = '0;
        for (int i = 0; i < NUM_DC_SYMS; i++) begin
            s[i] = SYM_W'(i);
        end
        return s;
    endfunction

    // canonical code assignment, evaluated at elaboration only
    function automatic t_rom build_rom(input t_counts counts, input t_syms syms,
                                       input int nsyms);
        t_rom        rom;
        int unsigned code;
        int          idx;
        rom  = '0;
        code = 0;
        idx  = 0;
        for (int len = 1; len <= NUM_LENGTHS; len++) begin
            for (int k = 0; k < int'(counts[len-1]); k++) begin
                if (idx < nsyms) begin
                    if (rom[syms[idx]][LEN_W+CODE_W-1:CODE_W] == '0) begin
                        rom[syms[idx]] = {LEN_W'(len), CODE_W'(code)};
                    end
                end
                code = code + 1;
                idx  = idx + 1;
            end
            code = code << 1;
        end
        return rom;
    endfunction

    localparam t_rom DC_LUMA_ROM   = build_rom(DC_LUMA_COUNTS, make_dc_syms(), NUM_DC_SYMS);
    localparam t_rom DC_CHROMA_ROM = build_rom(DC_CHROMA_COUNTS, make_dc_syms(), NUM_DC_SYMS);
    localparam t_rom AC_LUMA_ROM   = build_rom(AC_LUMA_COUNTS, AC_LUMA_SYMS, NUM_AC_SYMS);
    localparam t_rom AC_CHROMA_ROM = build_rom(AC_CHROMA_COUNTS, AC_CHROMA_SYMS, NUM_AC_SYMS);

endpackage

// ===== src/jhse_front.sv =====
module jhse_front (
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic [3:0]                          i_zero_run,
    input  logic signed [jhse_pkg::VALUE_W-1:0] i_coef_value,
    output logic                                o_push,
    input  logic                                i_full,
    output jhse_pkg::t_item                     o_item
);
    import jhse_pkg::*;

    logic [VALUE_W-1:0] sat_value;
    logic [VALUE_W-1:0] neg_value;
    logic [VALUE_W-1:0] dec_value;
    logic [EXTRA_W-1:0] mag;
    logic [EXTRA_W-1:0] mask;
    logic [CAT_W-1:0]   cat;
    logic               is_neg;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        // most negative code clamps to -2047
        sat_value = (i_coef_value == {1'b1, {(VALUE_W-1){1'b0}}})
                    ? {1'b1, {(VALUE_W-2){1'b0}}, 1'b1} : i_coef_value;
        is_neg    = sat_value[VALUE_W-1];
        neg_value = VALUE_W'(~sat_value + 1'b1);
        dec_value = VALUE_W'(sat_value - 1'b1);
        mag       = is_neg ? neg_value[EXTRA_W-1:0] : sat_value[EXTRA_W-1:0];

        cat = '0;
        for (int i = 0; i < EXTRA_W; i++) begin
            if (mag[i]) begin
                cat = CAT_W'(i + 1);
            end
        end

        for (int i = 0; i < EXTRA_W; i++) begin
            mask[i] = (CAT_W'(i) < cat);
        end

        o_item.is_ac = (i_func == FUNC_AC);
        o_item.cat   = cat;
        o_item.extra = (is_neg ? dec_value[EXTRA_W-1:0] : sat_value[EXTRA_W-1:0]) & mask;
        o_item.sym   = (i_func == FUNC_AC) ? {i_zero_run, cat} : {4'd0, cat};
    end

endmodule

// ===== src/jhse_fifo.sv =====
module jhse_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jhse_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output jhse_pkg::t_item o_item
);
    import jhse_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = 2'(r_count + {1'b0, i_push} - {1'b0, i_pop});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/jhse_back.sv =====
module jhse_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  jhse_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    input  jhse_pkg::t_item                     i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [jhse_pkg::CODE_W-1:0]         o_code_word,
    output logic [jhse_pkg::LEN_W-1:0]          o_code_length,
    output logic [jhse_pkg::EXTRA_W-1:0]        o_extra_bits,
    output logic [jhse_pkg::CAT_W-1:0]          o_extra_length
);
    import jhse_pkg::*;

    logic               r_valid;
    logic [CODE_W-1:0]  r_code;
    logic [LEN_W-1:0]   r_len;
    logic [EXTRA_W-1:0] r_extra;
    logic [CAT_W-1:0]   r_cat;
    t_rom_entry         entry;
    logic               load;

    // output register refills whenever it is empty or being drained
    assign load  = !r_valid || i_ready;
    assign o_pop = i_valid && load;

    always_comb begin
        if (i_item.is_ac) begin
            entry = i_cfg.ac_sel ? AC_CHROMA_ROM[i_item.sym] : AC_LUMA_ROM[i_item.sym];
        end else begin
            entry = i_cfg.dc_sel ? DC_CHROMA_ROM[i_item.sym] : DC_LUMA_ROM[i_item.sym];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code  <= entry[CODE_W-1:0];
            r_len   <= entry[LEN_W+CODE_W-1:CODE_W];
            r_extra <= i_item.extra;
            r_cat   <= i_item.cat;
        end
    end

    assign o_valid        = r_valid;
    assign o_code_word    = r_code;
    assign o_code_length  = r_len;
    assign o_extra_bits   = r_extra;
    assign o_extra_length = r_cat;

endmodule

// ===== src/jpeg_huffman_symbol_encoder.sv =====
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_func, i_zero_run, i_coef_value
// out       output     o_out_valid / i_out_ready  o_code_word, o_code_length,
//                                                 o_extra_bits, o_extra_length
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item per clock sustained while the output is not stalled; a transfer in is
// written to the queue, from which its table lookup loads the output register
// the two-entry queue between classifier and lookup absorbs output stalls;
// input ready drops only when the queue is full
// synchronous active-low reset clears the queue, the output valid and both
// table selects (luminance); the code tables are constants and need no fill
module jpeg_huffman_symbol_encoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_func,
    input  logic [3:0]                          i_zero_run,
    input  logic signed [jhse_pkg::VALUE_W-1:0] i_coef_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [jhse_pkg::CODE_W-1:0]         o_code_word,
    output logic [jhse_pkg::LEN_W-1:0]          o_code_length,
    output logic [jhse_pkg::EXTRA_W-1:0]        o_extra_bits,
    output logic [jhse_pkg::CAT_W-1:0]          o_extra_length,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jhse_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic                                i_cfg_data
);
    import jhse_pkg::*;

    t_cfg  r_cfg;
    t_cfg  n_cfg;
    t_item front_item;
    t_item queue_item;
    logic  push;
    logic  full;
    logic  queue_valid;
    logic  pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DC_TABLE_SEL: n_cfg.dc_sel = i_cfg_data;
                CFG_AC_TABLE_SEL: n_cfg.ac_sel = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    jhse_front u_front (
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_func       (i_func),
        .i_zero_run   (i_zero_run),
        .i_coef_value (i_coef_value),
        .o_push       (push),
        .i_full       (full),
        .o_item       (front_item)
    );

    jhse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_item  (queue_item)
    );

    jhse_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (queue_valid),
        .i_item         (queue_item),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_code_word    (o_code_word),
        .o_code_length  (o_code_length),
        .o_extra_bits   (o_extra_bits),
        .o_extra_length (o_extra_length)
    );

endmodule
